>>> sv/sfp_pkg.sv
// Package for the synchrophasor frame parser.
// Holds the status codes, framing constants and the result record.
// No dependencies.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam logic [7:0]  SYNC_LEADER = 8'hAA;
  localparam logic [15:0] MIN_FRAME   = 16'd16;
  localparam logic [15:0] MIN_HEAD    = 16'd18;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // Byte positions of the header fields within the frame.
  localparam logic [15:0] POS_TYPE     = 16'd1;
  localparam logic [15:0] POS_SIZE_END = 16'd3;
  localparam logic [15:0] POS_ID_END   = 16'd5;
  localparam logic [15:0] POS_SOC_END  = 16'd9;
  localparam logic [15:0] POS_FRAC_END = 16'd13;
  localparam logic [15:0] POS_HEAD_END = 16'd15;
  localparam logic [15:0] POS_BODY     = 16'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_SYNC = 3'd2,
    ST_BAD_SIZE = 3'd3,
    ST_BAD_CRC  = 3'd4
  } sfp_status_t;

  typedef struct packed {
    sfp_status_t status;
    logic [2:0]  frame_kind;
    logic [3:0]  version_number;
    logic [15:0] frame_bytes;
    logic [15:0] stream_id;
    logic [31:0] second_of_century;
    logic [31:0] fraction_of_second;
    logic [15:0] payload_length;
    logic [15:0] first_payload_word;
    logic        first_word_present;
  } sfp_result_t;

endpackage

>>> sv/sfp_crc.sv
// Byte-wide CRC-16/CCITT update, MSB first, no reflection.
// Depends on sfp_pkg for the polynomial.
`timescale 1ns / 1ps

module sfp_crc
  import sfp_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

>>> sv/sfp_track.sv
// Frame state tracker: byte counter, header capture, running CRC and verdict.
// Depends on sfp_pkg and sfp_crc.
`timescale 1ns / 1ps

module sfp_track
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  byte_in,
  input  logic        last,
  output sfp_result_t result
);

  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] crc_at_end, crc_at_end_next;
  logic [15:0] check_word, check_word_next;
  logic [7:0]  lead_byte, lead_byte_next;
  logic [7:0]  type_version_byte, type_version_byte_next;
  logic [15:0] size_field, size_field_next;
  logic [15:0] id_field, id_field_next;
  logic [31:0] soc_field, soc_field_next;
  logic [31:0] fracsec_field, fracsec_field_next;
  logic [15:0] payload_head, payload_head_next;
  logic [15:0] crc_upd;
  logic [16:0] idx_p1, idx_p2, size_wide;
  sfp_status_t status;

  sfp_crc u_crc (
    .crc_in  (running_crc),
    .data    (byte_in),
    .crc_out (crc_upd)
  );

  assign idx_p1    = {1'b0, byte_count} + 17'd1;
  assign idx_p2    = {1'b0, byte_count} + 17'd2;
  assign size_wide = {1'b0, size_field};

  always_comb begin
    crc_at_end_next        = crc_at_end;
    check_word_next        = check_word;
    lead_byte_next         = lead_byte;
    type_version_byte_next = type_version_byte;
    size_field_next        = size_field;
    id_field_next          = id_field;
    soc_field_next         = soc_field;
    fracsec_field_next     = fracsec_field;
    payload_head_next      = payload_head;

    // The CRC is latched just ahead of the two trailing check bytes.
    if (byte_count >= POS_BODY) begin
      if (idx_p2 == size_wide) begin
        crc_at_end_next = running_crc;
      end
      if (idx_p2 == size_wide || idx_p1 == size_wide) begin
        check_word_next = {check_word[7:0], byte_in};
      end
    end

    if (byte_count == 16'd0) begin
      lead_byte_next = byte_in;
    end else if (byte_count == POS_TYPE) begin
      type_version_byte_next = byte_in;
    end else if (byte_count <= POS_SIZE_END) begin
      size_field_next = {size_field[7:0], byte_in};
    end else if (byte_count <= POS_ID_END) begin
      id_field_next = {id_field[7:0], byte_in};
    end else if (byte_count <= POS_SOC_END) begin
      soc_field_next = {soc_field[23:0], byte_in};
    end else if (byte_count <= POS_FRAC_END) begin
      fracsec_field_next = {fracsec_field[23:0], byte_in};
    end else if (byte_count <= POS_HEAD_END) begin
      payload_head_next = {payload_head[7:0], byte_in};
    end

    running_crc_next = crc_upd;
    byte_count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  always_comb begin
    if (byte_count_next < MIN_FRAME) begin
      status = ST_SHORT;
    end else if (lead_byte_next != SYNC_LEADER) begin
      status = ST_BAD_SYNC;
    end else if (size_field_next < MIN_FRAME || size_field_next > byte_count_next) begin
      status = ST_BAD_SIZE;
    end else if (crc_at_end_next != check_word_next) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end

    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.frame_kind         = type_version_byte_next[6:4];
      result.version_number     = type_version_byte_next[3:0];
      result.frame_bytes        = size_field_next;
      result.stream_id          = id_field_next;
      result.second_of_century  = soc_field_next;
      result.fraction_of_second = fracsec_field_next;
      result.payload_length     = size_field_next - MIN_FRAME;
      if (size_field_next >= MIN_HEAD) begin
        result.first_payload_word = payload_head_next;
        result.first_word_present = 1'b1;
      end
    end
  end

  // The last byte of a buffer returns every register to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      byte_count        <= '0;
      running_crc       <= CRC_INIT;
      crc_at_end        <= '0;
      check_word        <= '0;
      lead_byte         <= '0;
      type_version_byte <= '0;
      size_field        <= '0;
      id_field          <= '0;
      soc_field         <= '0;
      fracsec_field     <= '0;
      payload_head      <= '0;
    end else if (accept) begin
      byte_count        <= byte_count_next;
      running_crc       <= running_crc_next;
      crc_at_end        <= crc_at_end_next;
      check_word        <= check_word_next;
      lead_byte         <= lead_byte_next;
      type_version_byte <= type_version_byte_next;
      size_field        <= size_field_next;
      id_field          <= id_field_next;
      soc_field         <= soc_field_next;
      fracsec_field     <= fracsec_field_next;
      payload_head      <= payload_head_next;
    end
  end

endmodule

>>> sv/synchrophasor_frame_parser.sv
// Synchrophasor frame parser: one byte per transaction, one result per buffer.
// Throughput: one byte per cycle unless stalled; header and CRC updates are combinational.
// The result sits in the output register in the cycle after the last byte is taken.
// Input stalls only while a finished result is held and the output is stalled.
// Reset (synchronous, active high) clears the frame state and empties the output register.
// Depends on sfp_pkg and sfp_track.
`timescale 1ns / 1ps

module synchrophasor_frame_parser
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  frame_kind,
  output logic [3:0]  version_number,
  output logic [15:0] frame_bytes,
  output logic [15:0] stream_id,
  output logic [31:0] second_of_century,
  output logic [31:0] fraction_of_second,
  output logic [15:0] payload_length,
  output logic [15:0] first_payload_word,
  output logic        first_word_present
);

  logic        accept;
  logic        out_take;
  sfp_result_t result;
  sfp_result_t result_q;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  sfp_track u_track (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (byte_in),
    .last    (end_of_buffer),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && end_of_buffer) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_buffer) begin
      result_q <= result;
    end
  end

  assign status             = result_q.status;
  assign frame_kind         = result_q.frame_kind;
  assign version_number     = result_q.version_number;
  assign frame_bytes        = result_q.frame_bytes;
  assign stream_id          = result_q.stream_id;
  assign second_of_century  = result_q.second_of_century;
  assign fraction_of_second = result_q.fraction_of_second;
  assign payload_length     = result_q.payload_length;
  assign first_payload_word = result_q.first_payload_word;
  assign first_word_present = result_q.first_word_present;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && end_of_buffer) |=> out_valid)
    else $error("last byte taken but no result presented");

  a_failed_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (frame_bytes == 16'd0 && payload_length == 16'd0
      && first_word_present == 1'b0))
    else $error("failed frame carries header fields");

  a_word_needs_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !first_word_present) |-> first_payload_word == 16'd0)
    else $error("payload word given without enough payload");

endmodule
